[design/lfs_pkg.sv]
// Package for the line-follow steering block: widths, register indexes,
// configuration reset values and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package lfs_pkg;

    // Defaults for the top-level parameters.
    localparam int SENSOR_COUNT_DEF = 8;
    localparam int SPECIAL_TURN_DEF = 1;

    // Field widths.
    localparam int SENS_W = 8;
    localparam int CORR_W = 16;
    localparam int BASE_W = 14;
    localparam int TGT_W  = 15;
    localparam int SPD_W  = 14;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Shared divider: dividend and divisor widths.
    localparam int DIV_W  = 16;
    localparam int DVSR_W = 12;
    localparam int DCNT_W = $clog2(DIV_W);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CORR_DIV  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORR_LIM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DIV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_LEFT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SIGN_MODE = 3'd7;

    // Register reset values.
    localparam logic [11:0]        RST_CORR_DIV  = 12'd1;
    localparam logic [12:0]        RST_CORR_LIM  = 13'd400;
    localparam logic [7:0]         RST_SLOW_DIV  = 8'd2;
    localparam logic [12:0]        RST_SLOW_MAX  = 13'd200;
    localparam logic [12:0]        RST_MIN_SPD   = 13'd50;
    localparam logic signed [13:0] RST_TURN_LEFT = 14'sd300;
    localparam logic [15:0]        RST_DELAY     = 16'd10;
    localparam logic [2:0]         RST_SIGN_MODE = 3'd0;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;        // latch the input transaction and step the steering mode
        logic div_start;     // start the shared divider
        logic div_sel_slow;  // divider operands: clamped correction by slowdown divisor
        logic clamp_load;    // clamp the first quotient into the speed correction
        logic slow_load;     // clamp the second quotient into the curve slowdown
        logic out_load;      // compute wheel targets into the output register
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic follow;    // the accepted transaction runs the follow arithmetic
        logic div_done;  // the divider is in its last step
        logic out_free;  // the output register can take a result this cycle
    } t_status;

endpackage

[design/line_follow_steering_fsm.sv]
// Top level of the line-follow steering block: joins the sequencer and the datapath.
// Depends on lfs_pkg, lfs_ctrl and lfs_datapath.
`timescale 1ns / 1ps

// Usage:
// Each input transaction is one control tick: the line-sensor bits, the raw steering
// correction and the two base wheel speeds. Each tick produces exactly one output
// transaction with both wheel targets, the clamped speed correction, the correction
// actually applied and the right-turn flag. Both channels use valid/ready.
// A tick in follow mode runs these steps from one acceptance to the next: the
// divider start after the mode step, a pass of the single shared radix-2 divider
// (correction by its divisor), the clamp, which also starts the second pass (the
// clamped magnitude by the slowdown divisor), the slowdown store, the output load
// and the idle state in which ready is high again and the next tick is taken.
// A tick in the wait, delay or turn states skips the divider.
// The result sits in an output register; the next tick is accepted while it waits.
// If the receiver stalls, the following result is held inside until the output
// register frees, and the input side stays not ready in the meantime.
// Synchronous active-low reset returns every configuration register to its default,
// the steering mode to follow and clears the held correction, the delay count and
// the curve slowdown. Configuration writes take effect at once and are meant to be
// made only while no tick is in flight.
module line_follow_steering_fsm #(
    parameter int SENSOR_COUNT = lfs_pkg::SENSOR_COUNT_DEF,
    parameter int SPECIAL_TURN = lfs_pkg::SPECIAL_TURN_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lfs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lfs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [lfs_pkg::SENS_W-1:0]           i_sensor_bits,
    input  logic signed [lfs_pkg::CORR_W-1:0]    i_raw_correction,
    input  logic signed [lfs_pkg::BASE_W-1:0]    i_base_speed_a,
    input  logic signed [lfs_pkg::BASE_W-1:0]    i_base_speed_b,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [lfs_pkg::TGT_W-1:0]     o_target_a,
    output logic signed [lfs_pkg::TGT_W-1:0]     o_target_b,
    output logic signed [lfs_pkg::SPD_W-1:0]     o_speed_correction,
    output logic signed [lfs_pkg::CORR_W-1:0]    o_applied_correction,
    output logic                                 o_right_turning
);
    import lfs_pkg::*;

    t_cmd    cmd;
    t_status status;

    // The sequencer owns the handshake on the input side and issues one command
    // per step; the datapath reports back whether the tick needs the divider.
    lfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds configuration, steering state and the output register.
    lfs_datapath #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .SPECIAL_TURN (SPECIAL_TURN)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_sensor_bits        (i_sensor_bits),
        .i_raw_correction     (i_raw_correction),
        .i_base_speed_a       (i_base_speed_a),
        .i_base_speed_b       (i_base_speed_b),
        .i_out_ready          (i_out_ready),
        .o_out_valid          (o_out_valid),
        .o_target_a           (o_target_a),
        .o_target_b           (o_target_b),
        .o_speed_correction   (o_speed_correction),
        .o_applied_correction (o_applied_correction),
        .o_right_turning      (o_right_turning)
    );

    // Only one tick is in flight: an accepted transaction closes the input side.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted again while a tick is in flight");

    // During the right turn wheel B stops and no correction is applied.
    a_turn_outputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_right_turning) |->
        (o_target_b == '0) && (o_speed_correction == '0) && (o_applied_correction == '0))
        else $error("right turn result carries a correction or a wheel B speed");

    // Reset leaves the block idle with no pending result.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("block not idle after reset");

endmodule

[design/lfs_div.sv]
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on lfs_pkg for the operand widths.
`timescale 1ns / 1ps

module lfs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lfs_pkg::DIV_W-1:0]   i_dividend,
    input  logic [lfs_pkg::DVSR_W-1:0]  i_divisor,
    output logic [lfs_pkg::DIV_W-1:0]   o_quotient,
    output logic                        o_done
);
    import lfs_pkg::*;

    logic                busy_q;
    logic                r_busy, n_busy;
    logic [DCNT_W-1:0]   r_cnt;
    logic [DVSR_W-1:0]   r_dvsr;
    logic [DVSR_W-1:0]   r_rem;
    logic [DIV_W-1:0]    r_quo;
    logic [DVSR_W:0]     trial;
    logic                fits;

    assign busy_q = r_busy;
    assign trial  = {r_rem, r_quo[DIV_W-1]};
    assign fits   = trial >= {1'b0, r_dvsr};
    assign o_done = busy_q && (r_cnt == DCNT_W'(DIV_W - 1));
    assign o_quotient = r_quo;

    always_comb begin
        n_busy = r_busy;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (o_done) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            if (i_start) begin
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvsr <= i_divisor;
            r_rem  <= '0;
            r_quo  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? DVSR_W'(trial - {1'b0, r_dvsr}) : trial[DVSR_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

endmodule

[design/lfs_datapath.sv]
// Datapath of the line-follow steering block: configuration registers,
// steering mode, correction arithmetic, wheel targets and output register.
// Depends on lfs_pkg and lfs_div.
`timescale 1ns / 1ps

module lfs_datapath #(
    parameter int SENSOR_COUNT = lfs_pkg::SENSOR_COUNT_DEF,
    parameter int SPECIAL_TURN = lfs_pkg::SPECIAL_TURN_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lfs_pkg::t_cmd                        i_cmd,
    output lfs_pkg::t_status                     o_status,
    input  logic                                 i_cfg_we,
    input  logic [lfs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lfs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [lfs_pkg::SENS_W-1:0]           i_sensor_bits,
    input  logic signed [lfs_pkg::CORR_W-1:0]    i_raw_correction,
    input  logic signed [lfs_pkg::BASE_W-1:0]    i_base_speed_a,
    input  logic signed [lfs_pkg::BASE_W-1:0]    i_base_speed_b,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [lfs_pkg::TGT_W-1:0]     o_target_a,
    output logic signed [lfs_pkg::TGT_W-1:0]     o_target_b,
    output logic signed [lfs_pkg::SPD_W-1:0]     o_speed_correction,
    output logic signed [lfs_pkg::CORR_W-1:0]    o_applied_correction,
    output logic                                 o_right_turning
);
    import lfs_pkg::*;

    typedef enum logic [3:0] {
        M_FOLLOW = 4'b0001,
        M_WAIT   = 4'b0010,
        M_DELAY  = 4'b0100,
        M_TURN   = 4'b1000
    } t_mode;

    localparam logic [SENS_W-1:0] ALL_ON = SENS_W'((9'd1 << SENSOR_COUNT) - 9'd1);

    // Configuration registers.
    logic [11:0]        r_corr_div;
    logic [12:0]        r_corr_lim;
    logic [7:0]         r_slow_div;
    logic [12:0]        r_slow_max;
    logic [12:0]        r_min_spd;
    logic signed [13:0] r_turn_left;
    logic [15:0]        r_delay;
    logic [2:0]         r_sign_mode;

    // Steering state.
    t_mode              r_mode, n_mode;
    logic [15:0]        r_dcount, n_dcount;
    logic signed [CORR_W-1:0] r_last;
    logic [12:0]        r_slowdown;

    // Per-transaction working registers.
    logic               r_follow, n_follow;
    logic               r_neg;
    logic [DIV_W-1:0]   r_abs;
    logic signed [CORR_W-1:0] r_applied;
    logic signed [SPD_W-1:0]  r_mmps;
    logic signed [BASE_W-1:0] r_base_a, r_base_b;

    // Output register.
    logic               r_out_valid;
    logic signed [TGT_W-1:0]  r_tgt_a, r_tgt_b;
    logic signed [SPD_W-1:0]  r_out_spd;
    logic signed [CORR_W-1:0] r_out_applied;
    logic               r_out_turn;

    logic [SENS_W-1:0]  bits;
    logic signed [CORR_W-1:0] corr_sel;
    logic [DIV_W-1:0]   div_a;
    logic [DVSR_W-1:0]  div_b;
    logic [DIV_W-1:0]   quo;
    logic               div_done;
    logic [11:0]        cdiv;
    logic [7:0]         sdiv;
    logic [12:0]        mag;
    logic [12:0]        slow_new;
    logic signed [SPD_W-1:0] delta_a, delta_b;
    logic               turning;

    function automatic logic signed [TGT_W-1:0] f_wheel(
        input logic signed [BASE_W-1:0] base,
        input logic signed [SPD_W-1:0]  delta,
        input logic [12:0]              slow,
        input logic [12:0]              minv
    );
        logic              fwd;
        logic signed [15:0] absb;
        logic signed [15:0] m;
        logic signed [15:0] mn;
        logic signed [15:0] t;
        fwd  = !base[BASE_W-1];
        mn   = $signed({3'b000, minv});
        absb = fwd ? 16'(base) : -16'(base);
        m    = absb - $signed({3'b000, slow});
        if (m < mn) begin
            m = mn;
        end
        t = (fwd ? m : -m) + 16'(delta);
        if (fwd && (t < mn)) begin
            t = mn;
        end else if (!fwd && (t > -mn)) begin
            t = -mn;
        end
        return t[TGT_W-1:0];
    endfunction

    assign bits = i_sensor_bits & ALL_ON;

    // Steering mode step, evaluated on the accepted transaction.
    always_comb begin
        n_mode   = r_mode;
        n_dcount = r_dcount;
        n_follow = 1'b1;
        if (SPECIAL_TURN != 0) begin
            case (r_mode)
                M_FOLLOW: begin
                    if (bits[6:4] == 3'b111) begin
                        n_mode   = M_WAIT;
                        n_follow = 1'b0;
                    end
                end
                M_WAIT: begin
                    n_follow = 1'b0;
                    if ((bits == '0) || (bits == ALL_ON)) begin
                        n_mode   = M_DELAY;
                        n_dcount = r_delay;
                    end
                end
                M_DELAY: begin
                    n_follow = 1'b0;
                    if (r_dcount != '0) begin
                        n_dcount = r_dcount - 1'b1;
                    end
                    if ((r_dcount == 16'd0) || (r_dcount == 16'd1)) begin
                        n_mode = M_TURN;
                    end
                end
                M_TURN: begin
                    n_follow = 1'b0;
                    if (bits[4:2] != 3'b000) begin
                        n_mode = M_FOLLOW;
                    end
                end
                default: begin
                    n_mode = M_FOLLOW;
                end
            endcase
        end else begin
            n_mode = M_FOLLOW;
        end
    end

    // A lost line reuses the last correction accepted in a follow tick with the line in view.
    assign corr_sel = (bits == '0) ? r_last : i_raw_correction;

    assign cdiv = (r_corr_div == '0) ? 12'd1 : r_corr_div;
    assign sdiv = (r_slow_div == '0) ? 8'd1 : r_slow_div;

    assign mag      = (quo > {3'b000, r_corr_lim}) ? r_corr_lim : quo[12:0];
    assign slow_new = (quo > {3'b000, r_slow_max}) ? r_slow_max : quo[12:0];

    assign div_a = i_cmd.div_sel_slow ? {3'b000, mag} : r_abs;
    assign div_b = i_cmd.div_sel_slow ? {4'b0000, sdiv} : cdiv;

    lfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    assign delta_a = r_sign_mode[1] ? -r_mmps : r_mmps;
    assign delta_b = r_sign_mode[2] ? r_mmps : -r_mmps;
    assign turning = (r_mode == M_TURN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corr_div  <= RST_CORR_DIV;
            r_corr_lim  <= RST_CORR_LIM;
            r_slow_div  <= RST_SLOW_DIV;
            r_slow_max  <= RST_SLOW_MAX;
            r_min_spd   <= RST_MIN_SPD;
            r_turn_left <= RST_TURN_LEFT;
            r_delay     <= RST_DELAY;
            r_sign_mode <= RST_SIGN_MODE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CORR_DIV:  r_corr_div  <= i_cfg_data[11:0];
                REG_CORR_LIM:  r_corr_lim  <= i_cfg_data[12:0];
                REG_SLOW_DIV:  r_slow_div  <= i_cfg_data[7:0];
                REG_SLOW_MAX:  r_slow_max  <= i_cfg_data[12:0];
                REG_MIN_SPD:   r_min_spd   <= i_cfg_data[12:0];
                REG_TURN_LEFT: r_turn_left <= $signed(i_cfg_data[13:0]);
                REG_DELAY:     r_delay     <= i_cfg_data;
                REG_SIGN_MODE: r_sign_mode <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_FOLLOW;
            r_dcount    <= '0;
            r_last      <= '0;
            r_slowdown  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_mode   <= n_mode;
                r_dcount <= n_dcount;
                if (n_follow && (bits != '0)) begin
                    r_last <= i_raw_correction;
                end
            end
            if (i_cmd.slow_load) begin
                r_slowdown <= slow_new;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_follow  <= n_follow;
            r_base_a  <= i_base_speed_a;
            r_base_b  <= i_base_speed_b;
            r_mmps    <= '0;
            r_applied <= n_follow ? corr_sel : '0;
            r_neg     <= corr_sel[CORR_W-1] ^ r_sign_mode[0];
            r_abs     <= corr_sel[CORR_W-1] ? DIV_W'(-corr_sel) : DIV_W'(corr_sel);
        end
        if (i_cmd.clamp_load) begin
            r_mmps <= r_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
        if (i_cmd.out_load) begin
            r_tgt_a       <= turning ? TGT_W'(r_turn_left)
                                     : f_wheel(r_base_a, delta_a, r_slowdown, r_min_spd);
            r_tgt_b       <= turning ? '0
                                     : f_wheel(r_base_b, delta_b, r_slowdown, r_min_spd);
            r_out_spd     <= r_mmps;
            r_out_applied <= r_applied;
            r_out_turn    <= turning;
        end
    end

    assign o_status.follow   = r_follow;
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid          = r_out_valid;
    assign o_target_a           = r_tgt_a;
    assign o_target_b           = r_tgt_b;
    assign o_speed_correction   = r_out_spd;
    assign o_applied_correction = r_out_applied;
    assign o_right_turning      = r_out_turn;

endmodule

[design/lfs_ctrl.sv]
// Sequencer of the line-follow steering block: walks one transaction through
// mode update, two divider passes and clamping in follow ticks, and output load.
// Depends on lfs_pkg for the command and status structs.
`timescale 1ns / 1ps

module lfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lfs_pkg::t_status  i_status,
    output lfs_pkg::t_cmd     o_cmd
);
    import lfs_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_DIV1  = 7'b0000100,
        S_CLAMP = 7'b0001000,
        S_DIV2  = 7'b0010000,
        S_SLOW  = 7'b0100000,
        S_WHEEL = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_START;
                end
            end
            S_START: begin
                if (i_status.follow) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV1;
                end else begin
                    n_state = S_WHEEL;
                end
            end
            S_DIV1: begin
                if (i_status.div_done) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                o_cmd.clamp_load   = 1'b1;
                o_cmd.div_start    = 1'b1;
                o_cmd.div_sel_slow = 1'b1;
                n_state            = S_DIV2;
            end
            S_DIV2: begin
                if (i_status.div_done) begin
                    n_state = S_SLOW;
                end
            end
            S_SLOW: begin
                o_cmd.slow_load    = 1'b1;
                o_cmd.div_sel_slow = 1'b1;
                n_state            = S_WHEEL;
            end
            S_WHEEL: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
